/* sv/spit_pkg.sv */
// Package with the widths, kind codes and stage payload types of the shape pair test.
`timescale 1ns / 1ps

package spit_pkg;

  // Width of one packed coordinate (signed Q8.8 at the default of 16).
  localparam int COORD_BITS = 16;
  localparam int CW = COORD_BITS;
  // Radius width, fixed by the input fields.
  localparam int RW = 16;

  // Sums and differences of coordinates grow by one bit per step.
  localparam int DW = CW + 1;
  localparam int AW = CW + 2;
  localparam int BW = CW + 3;

  // Circle-circle compare width: squared distance against squared radius sum.
  localparam int CCW = (2 * DW + 1 > 2 * RW + 4) ? 2 * DW + 1 : 2 * RW + 4;
  // Segment squares compare width: endpoint distances against r squared.
  localparam int SGW = (2 * BW + 1 > 2 * RW + 2) ? 2 * BW + 1 : 2 * RW + 2;
  // Cross product width and the split of its magnitude for squaring.
  localparam int XW  = CW + AW + 1;
  localparam int XH  = (XW + 1) / 2;
  // Dot product width.
  localparam int DTW = CW + BW + 1;
  // Width of the squared cross product against r squared times length squared.
  localparam int CRW = (2 * XW > 2 * RW + 2 * CW) ? 2 * XW : 2 * RW + 2 * CW;

  typedef enum logic [1:0] {
    KIND_CC   = 2'd0,
    KIND_CS   = 2'd1,
    KIND_SC   = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef logic        [2*CW-1:0] pt_t;
  typedef logic signed [CW-1:0]   crd_t;
  typedef logic signed [DW-1:0]   dsum_t;
  typedef logic signed [AW-1:0]   ax_t;
  typedef logic signed [BW-1:0]   bx_t;
  typedef logic        [RW-1:0]   rad_t;
  typedef logic        [RW:0]     rsum_t;
  typedef logic signed [CCW-1:0]  cc_t;
  typedef logic signed [SGW-1:0]  sg_t;
  typedef logic signed [XW-1:0]   xp_t;
  typedef logic signed [DTW-1:0]  dt_t;
  typedef logic        [XW-1:0]   xm_t;
  typedef logic        [2*RW-1:0] rr_t;
  typedef logic        [2*CW-1:0] ss_t;
  typedef logic        [CRW-1:0]  cr_t;

  // Stage 1: differences and the selected circle and segment.
  typedef struct packed {
    kind_t kind;
    dsum_t dx;
    dsum_t dy;
    rsum_t rs;
    rad_t  r;
    crd_t  vx;
    crd_t  vy;
    ax_t   ax;
    ax_t   ay;
    bx_t   bx;
    bx_t   by;
  } s1_t;

  // Stage 2: all first level products.
  typedef struct packed {
    kind_t kind;
    cc_t   dxx;
    cc_t   dyy;
    cc_t   rs2;
    sg_t   rr;
    sg_t   vxx;
    sg_t   vyy;
    sg_t   axx;
    sg_t   ayy;
    sg_t   bxx;
    sg_t   byy;
    xp_t   cva;
    xp_t   cvb;
    dt_t   dax;
    dt_t   day;
    dt_t   dbx;
    dt_t   dby;
  } s2_t;

  // Stage 3: decided flags plus the operands of the distance-to-line test.
  typedef struct packed {
    kind_t kind;
    logic  cc_hit;
    logic  ss_zero;
    logic  in_a;
    logic  in_b;
    logic  proj;
    xm_t   cm;
    rr_t   rr;
    ss_t   ss;
  } s3_t;

  // Stage 4: partial products of the squared cross product and r squared times length.
  typedef struct packed {
    kind_t kind;
    logic  cc_hit;
    logic  ss_zero;
    logic  in_a;
    logic  in_b;
    logic  proj;
    cr_t   hh;
    cr_t   hl;
    cr_t   ll;
    cr_t   rs;
  } s4_t;

endpackage

/* sv/shape_pair_intersect_test_unit.sv */
// Top level of the shape pair intersection test pipeline.
`timescale 1ns / 1ps

// Decides whether the two shapes of one pair touch: circle-circle, circle-segment
// in either order, or an unsupported pair that always misses. Points arrive
// packed, x in the low half and y in the high half, each signed Q8.8.
// The input channel (in_valid, in_stall, in_* fields) carries one pair per
// transfer; the result channel (out_valid, out_stall, out_hit) carries one
// flag per pair, in the order the pairs came in.
// The work runs through five register stages: differences, products, sums,
// partial products of the squared cross product, and the final decision.
// The pipeline takes a new pair in every cycle while in_stall is low, so
// throughput is one pair per cycle as long as the receiver does not stall;
// the multiplier stage sets that rate, as every product has its own
// multiplier.
// Reset (rst_n low at a clock edge) clears only the stage valid bits; the data
// registers are not reset. When the receiver stalls, the held result stays put
// and the stages behind it keep filling their empty slots; in_stall rises only
// when every stage holds a pair, so nothing is dropped or repeated.
module shape_pair_intersect_test_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_req_type,
  input  spit_pkg::pt_t  in_pos_a,
  input  spit_pkg::pt_t  in_pos_b,
  input  spit_pkg::rad_t in_radius_a,
  input  spit_pkg::rad_t in_radius_b,
  input  spit_pkg::pt_t  in_offset_a,
  input  spit_pkg::pt_t  in_offset_b,
  input  spit_pkg::pt_t  in_seg_vec,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_hit
);

  // Each stage moves forward when its successor is empty or moving itself.
  logic          rdy1, rdy2, rdy3, rdy4;
  logic          v1, v2, v3;
  spit_pkg::s1_t s1;
  spit_pkg::s2_t s2;
  spit_pkg::s3_t s3;

  assign in_stall = !rdy1;

  spit_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (in_valid),
    .ready_in  (rdy1),
    .ready_out (rdy2),
    .req_type  (in_req_type),
    .pos_a     (in_pos_a),
    .pos_b     (in_pos_b),
    .radius_a  (in_radius_a),
    .radius_b  (in_radius_b),
    .offset_a  (in_offset_a),
    .offset_b  (in_offset_b),
    .seg_vec   (in_seg_vec),
    .valid_r   (v1),
    .s1_r      (s1)
  );

  spit_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (v1),
    .ready_in  (rdy2),
    .ready_out (rdy3),
    .s1        (s1),
    .valid_r   (v2),
    .s2_r      (s2)
  );

  spit_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (v2),
    .ready_in  (rdy3),
    .ready_out (rdy4),
    .s2        (s2),
    .valid_r   (v3),
    .s3_r      (s3)
  );

  // The last stage's register is the output register of the result channel.
  spit_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (v3),
    .ready_in  (rdy4),
    .stall_out (out_stall),
    .s3        (s3),
    .valid_r   (out_valid),
    .hit_r     (out_hit)
  );

endmodule

/* sv/spit_prep.sv */
// First stage: unpacks the points, selects circle and segment, forms the differences.
`timescale 1ns / 1ps

module spit_prep (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_in,
  output logic           ready_in,
  input  logic           ready_out,
  input  logic [1:0]     req_type,
  input  spit_pkg::pt_t  pos_a,
  input  spit_pkg::pt_t  pos_b,
  input  spit_pkg::rad_t radius_a,
  input  spit_pkg::rad_t radius_b,
  input  spit_pkg::pt_t  offset_a,
  input  spit_pkg::pt_t  offset_b,
  input  spit_pkg::pt_t  seg_vec,
  output logic           valid_r,
  output spit_pkg::s1_t  s1_r
);

  spit_pkg::kind_t  kind;
  logic             swap;
  spit_pkg::crd_t   pax, pay, pbx, pby;
  spit_pkg::crd_t   cx, cy, cox, coy, sx, sy, sox, soy;
  spit_pkg::dsum_t  px, py, qx, qy;
  spit_pkg::ax_t    ax, ay;
  spit_pkg::s1_t    s1_nxt;

  assign ready_in = !valid_r || ready_out;
  assign kind     = spit_pkg::kind_t'(req_type);
  // Segment on side A: the circle is body B.
  assign swap     = (kind == spit_pkg::KIND_SC);

  assign pax = $signed(pos_a[spit_pkg::CW-1:0]);
  assign pay = $signed(pos_a[2*spit_pkg::CW-1:spit_pkg::CW]);
  assign pbx = $signed(pos_b[spit_pkg::CW-1:0]);
  assign pby = $signed(pos_b[2*spit_pkg::CW-1:spit_pkg::CW]);

  always_comb begin
    if (swap) begin
      cx  = pbx;
      cy  = pby;
      cox = $signed(offset_b[spit_pkg::CW-1:0]);
      coy = $signed(offset_b[2*spit_pkg::CW-1:spit_pkg::CW]);
      sx  = pax;
      sy  = pay;
      sox = $signed(offset_a[spit_pkg::CW-1:0]);
      soy = $signed(offset_a[2*spit_pkg::CW-1:spit_pkg::CW]);
    end else begin
      cx  = pax;
      cy  = pay;
      cox = $signed(offset_a[spit_pkg::CW-1:0]);
      coy = $signed(offset_a[2*spit_pkg::CW-1:spit_pkg::CW]);
      sx  = pbx;
      sy  = pby;
      sox = $signed(offset_b[spit_pkg::CW-1:0]);
      soy = $signed(offset_b[2*spit_pkg::CW-1:spit_pkg::CW]);
    end
  end

  always_comb begin
    px = spit_pkg::dsum_t'(cx) + spit_pkg::dsum_t'(cox);
    py = spit_pkg::dsum_t'(cy) + spit_pkg::dsum_t'(coy);
    qx = spit_pkg::dsum_t'(sx) + spit_pkg::dsum_t'(sox);
    qy = spit_pkg::dsum_t'(sy) + spit_pkg::dsum_t'(soy);
    ax = spit_pkg::ax_t'(px) - spit_pkg::ax_t'(qx);
    ay = spit_pkg::ax_t'(py) - spit_pkg::ax_t'(qy);

    s1_nxt.kind = kind;
    s1_nxt.dx   = spit_pkg::dsum_t'(pax) - spit_pkg::dsum_t'(pbx);
    s1_nxt.dy   = spit_pkg::dsum_t'(pay) - spit_pkg::dsum_t'(pby);
    s1_nxt.rs   = {1'b0, radius_a} + {1'b0, radius_b};
    s1_nxt.r    = swap ? radius_b : radius_a;
    s1_nxt.vx   = $signed(seg_vec[spit_pkg::CW-1:0]);
    s1_nxt.vy   = $signed(seg_vec[2*spit_pkg::CW-1:spit_pkg::CW]);
    s1_nxt.ax   = ax;
    s1_nxt.ay   = ay;
    s1_nxt.bx   = spit_pkg::bx_t'(ax) - spit_pkg::bx_t'(s1_nxt.vx);
    s1_nxt.by   = spit_pkg::bx_t'(ay) - spit_pkg::bx_t'(s1_nxt.vy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_in) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

/* sv/spit_mul.sv */
// Second stage: all squares and cross terms of the differences and the segment vector.
`timescale 1ns / 1ps

module spit_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_in,
  output logic          ready_in,
  input  logic          ready_out,
  input  spit_pkg::s1_t s1,
  output logic          valid_r,
  output spit_pkg::s2_t s2_r
);

  spit_pkg::s2_t s2_nxt;

  assign ready_in = !valid_r || ready_out;

  always_comb begin
    s2_nxt.kind = s1.kind;
    s2_nxt.dxx  = spit_pkg::cc_t'(s1.dx) * spit_pkg::cc_t'(s1.dx);
    s2_nxt.dyy  = spit_pkg::cc_t'(s1.dy) * spit_pkg::cc_t'(s1.dy);
    s2_nxt.rs2  = spit_pkg::cc_t'({1'b0, s1.rs}) * spit_pkg::cc_t'({1'b0, s1.rs});
    s2_nxt.rr   = spit_pkg::sg_t'({1'b0, s1.r}) * spit_pkg::sg_t'({1'b0, s1.r});
    s2_nxt.vxx  = spit_pkg::sg_t'(s1.vx) * spit_pkg::sg_t'(s1.vx);
    s2_nxt.vyy  = spit_pkg::sg_t'(s1.vy) * spit_pkg::sg_t'(s1.vy);
    s2_nxt.axx  = spit_pkg::sg_t'(s1.ax) * spit_pkg::sg_t'(s1.ax);
    s2_nxt.ayy  = spit_pkg::sg_t'(s1.ay) * spit_pkg::sg_t'(s1.ay);
    s2_nxt.bxx  = spit_pkg::sg_t'(s1.bx) * spit_pkg::sg_t'(s1.bx);
    s2_nxt.byy  = spit_pkg::sg_t'(s1.by) * spit_pkg::sg_t'(s1.by);
    s2_nxt.cva  = spit_pkg::xp_t'(s1.vx) * spit_pkg::xp_t'(s1.ay);
    s2_nxt.cvb  = spit_pkg::xp_t'(s1.vy) * spit_pkg::xp_t'(s1.ax);
    s2_nxt.dax  = spit_pkg::dt_t'(s1.ax) * spit_pkg::dt_t'(s1.vx);
    s2_nxt.day  = spit_pkg::dt_t'(s1.ay) * spit_pkg::dt_t'(s1.vy);
    s2_nxt.dbx  = spit_pkg::dt_t'(s1.bx) * spit_pkg::dt_t'(s1.vx);
    s2_nxt.dby  = spit_pkg::dt_t'(s1.by) * spit_pkg::dt_t'(s1.vy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_in) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

/* sv/spit_sum.sv */
// Third stage: sums of products, the circle-circle decision and the endpoint tests.
`timescale 1ns / 1ps

module spit_sum (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_in,
  output logic          ready_in,
  input  logic          ready_out,
  input  spit_pkg::s2_t s2,
  output logic          valid_r,
  output spit_pkg::s3_t s3_r
);

  spit_pkg::cc_t d2;
  spit_pkg::sg_t ss, aa, bb;
  spit_pkg::xp_t xprod;
  spit_pkg::dt_t da, db;
  spit_pkg::s3_t s3_nxt;

  assign ready_in = !valid_r || ready_out;

  always_comb begin
    d2    = s2.dxx + s2.dyy;
    ss    = s2.vxx + s2.vyy;
    aa    = s2.axx + s2.ayy;
    bb    = s2.bxx + s2.byy;
    xprod = s2.cva - s2.cvb;
    da    = s2.dax + s2.day;
    db    = s2.dbx + s2.dby;

    s3_nxt.kind    = s2.kind;
    s3_nxt.cc_hit  = (d2 <= s2.rs2);
    s3_nxt.ss_zero = (ss == '0);
    s3_nxt.in_a    = (s2.rr > aa);
    s3_nxt.in_b    = (s2.rr > bb);
    // The centre projects onto the segment when the two dot products do not
    // share a strict sign.
    s3_nxt.proj    = (da == '0) || (db == '0) ||
                     (da[spit_pkg::DTW-1] != db[spit_pkg::DTW-1]);
    s3_nxt.cm      = xprod[spit_pkg::XW-1] ? spit_pkg::xm_t'(-xprod)
                                           : spit_pkg::xm_t'(xprod);
    s3_nxt.rr      = s2.rr[2*spit_pkg::RW-1:0];
    s3_nxt.ss      = ss[2*spit_pkg::CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_in) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

/* sv/spit_final.sv */
// Last two stages: squares the cross product in halves and makes the hit decision.
`timescale 1ns / 1ps

module spit_final (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_in,
  output logic          ready_in,
  input  logic          stall_out,
  input  spit_pkg::s3_t s3,
  output logic          valid_r,
  output logic          hit_r
);

  localparam int XLO = spit_pkg::XH;

  logic                             v4_r;
  logic                             ready5;
  logic [spit_pkg::XW-XLO-1:0]      hi;
  logic [XLO-1:0]                   lo;
  spit_pkg::s4_t                    s4_r, s4_nxt;
  spit_pkg::cr_t                    c2;
  logic                             seg_hit;
  logic                             hit_nxt;

  assign ready5   = !valid_r || !stall_out;
  assign ready_in = !v4_r || ready5;

  assign hi = s3.cm[spit_pkg::XW-1:XLO];
  assign lo = s3.cm[XLO-1:0];

  always_comb begin
    s4_nxt.kind    = s3.kind;
    s4_nxt.cc_hit  = s3.cc_hit;
    s4_nxt.ss_zero = s3.ss_zero;
    s4_nxt.in_a    = s3.in_a;
    s4_nxt.in_b    = s3.in_b;
    s4_nxt.proj    = s3.proj;
    s4_nxt.hh      = spit_pkg::cr_t'(hi) * spit_pkg::cr_t'(hi);
    s4_nxt.hl      = spit_pkg::cr_t'(hi) * spit_pkg::cr_t'(lo);
    s4_nxt.ll      = spit_pkg::cr_t'(lo) * spit_pkg::cr_t'(lo);
    s4_nxt.rs      = spit_pkg::cr_t'(s3.rr) * spit_pkg::cr_t'(s3.ss);
  end

  always_comb begin
    c2 = (s4_r.hh << (2 * XLO)) + (s4_r.hl << (XLO + 1)) + s4_r.ll;
    // A point segment hits only from strictly inside the circle.
    if (s4_r.ss_zero) begin
      seg_hit = s4_r.in_a;
    end else if (c2 > s4_r.rs) begin
      seg_hit = 1'b0;
    end else if (s4_r.proj) begin
      seg_hit = 1'b1;
    end else begin
      seg_hit = s4_r.in_a || s4_r.in_b;
    end
    case (s4_r.kind)
      spit_pkg::KIND_CC: hit_nxt = s4_r.cc_hit;
      spit_pkg::KIND_CS: hit_nxt = seg_hit;
      spit_pkg::KIND_SC: hit_nxt = seg_hit;
      default:           hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r    <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (ready_in) begin
        v4_r <= valid_in;
      end
      if (ready5) begin
        valid_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      s4_r <= s4_nxt;
    end
    if (ready5 && v4_r) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the shape pair intersection test unit.
`timescale 1ns / 1ps

module testbench;

  // Run control. The watchdog ends the run if this many cycles pass with no
  // transfer on either channel.
  localparam int RESET_CYCLES  = 6;
  localparam int PAIRS_A_PHASE = 134;
  localparam int STUCK_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 16;

  // One shape pair as it goes on the input channel. Directed rows may carry a
  // hand-worked answer; for all other pairs the predictor supplies it.
  typedef struct {
    spit_pkg::kind_t kind;
    spit_pkg::pt_t   pos_a;
    spit_pkg::pt_t   pos_b;
    spit_pkg::rad_t  radius_a;
    spit_pkg::rad_t  radius_b;
    spit_pkg::pt_t   offset_a;
    spit_pkg::pt_t   offset_b;
    spit_pkg::pt_t   seg_vec;
    bit              typed;
    bit              typed_hit;
  } shape_pair_t;

  // Signed scratch width for the predictor. The largest product, the squared
  // cross product, needs at most 70 bits, so 128 never overflows.
  typedef logic signed [127:0] wide_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall;
  logic        out_hit;
  shape_pair_t pair_on_port;

  // Expected hit flags of pairs that went in and whose result is still due.
  bit hits_due_q[$];
  int fail_count = 0;
  int stuck_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  shape_pair_intersect_test_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (pair_on_port.kind),
    .in_pos_a    (pair_on_port.pos_a),
    .in_pos_b    (pair_on_port.pos_b),
    .in_radius_a (pair_on_port.radius_a),
    .in_radius_b (pair_on_port.radius_b),
    .in_offset_a (pair_on_port.offset_a),
    .in_offset_b (pair_on_port.offset_b),
    .in_seg_vec  (pair_on_port.seg_vec),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_hit     (out_hit)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Packs a point from integer coordinates, x in the low half, y in the high.
  function automatic spit_pkg::pt_t pk(int x, int y);
    return {y[spit_pkg::CW-1:0], x[spit_pkg::CW-1:0]};
  endfunction

  // Extracts one signed coordinate of a packed point: x when upper is 0.
  function automatic wide_t coord(spit_pkg::pt_t p, bit upper);
    wide_t v;
    if (upper)
      v = wide_t'($signed(p[2*spit_pkg::CW-1:spit_pkg::CW]));
    else
      v = wide_t'($signed(p[spit_pkg::CW-1:0]));
    return v;
  endfunction

  function automatic shape_pair_t mk(spit_pkg::kind_t kind, spit_pkg::pt_t pos_a,
                                     spit_pkg::pt_t pos_b, spit_pkg::rad_t radius_a,
                                     spit_pkg::rad_t radius_b, spit_pkg::pt_t offset_a,
                                     spit_pkg::pt_t offset_b, spit_pkg::pt_t seg_vec,
                                     bit typed, bit typed_hit);
    shape_pair_t p;
    p.kind      = kind;
    p.pos_a     = pos_a;
    p.pos_b     = pos_b;
    p.radius_a  = radius_a;
    p.radius_b  = radius_b;
    p.offset_a  = offset_a;
    p.offset_b  = offset_b;
    p.seg_vec   = seg_vec;
    p.typed     = typed;
    p.typed_hit = typed_hit;
    return p;
  endfunction

  // Circle against segment, all in exact integer squares. The circle centre is
  // its body position plus offset; the segment starts at its body position
  // plus offset and runs along the vector.
  function automatic bit circle_meets_segment(spit_pkg::rad_t radius, spit_pkg::pt_t cpos,
                                              spit_pkg::pt_t coff, spit_pkg::pt_t spos,
                                              spit_pkg::pt_t soff, spit_pkg::pt_t vec);
    wide_t r, rr, ax, ay, bx, by, vx, vy, ss, aa, bb, xprod, da, db;
    r  = wide_t'(radius);
    rr = r * r;
    vx = coord(vec, 0);
    vy = coord(vec, 1);
    ax = coord(cpos, 0) + coord(coff, 0) - (coord(spos, 0) + coord(soff, 0));
    ay = coord(cpos, 1) + coord(coff, 1) - (coord(spos, 1) + coord(soff, 1));
    bx = ax - vx;
    by = ay - vy;
    ss = vx * vx + vy * vy;
    aa = ax * ax + ay * ay;
    bb = bx * bx + by * by;
    // A zero-length segment is a point that must lie strictly inside.
    if (ss == 0)
      return rr > aa;
    // Distance from the centre to the segment's line exceeds the radius.
    xprod = vx * ay - vy * ax;
    if (xprod * xprod > rr * ss)
      return 1'b0;
    // The centre projects onto the segment, endpoints included.
    da = ax * vx + ay * vy;
    db = bx * vx + by * vy;
    if (da == 0 || db == 0 || ((da < 0) != (db < 0)))
      return 1'b1;
    return (rr > aa) || (rr > bb);
  endfunction

  // Predicts the hit flag of one pair. Circle-circle looks at body positions
  // only; offsets play no part there. The segment side's radius never matters.
  function automatic bit shapes_touch(shape_pair_t p);
    wide_t dx, dy, rs;
    case (p.kind)
      spit_pkg::KIND_CC: begin
        dx = coord(p.pos_a, 0) - coord(p.pos_b, 0);
        dy = coord(p.pos_a, 1) - coord(p.pos_b, 1);
        rs = wide_t'(p.radius_a) + wide_t'(p.radius_b);
        return dx * dx + dy * dy <= rs * rs;
      end
      spit_pkg::KIND_CS: return circle_meets_segment(p.radius_a, p.pos_a, p.offset_a,
                                                     p.pos_b, p.offset_b, p.seg_vec);
      spit_pkg::KIND_SC: return circle_meets_segment(p.radius_b, p.pos_b, p.offset_b,
                                                     p.pos_a, p.offset_a, p.seg_vec);
      default: return 1'b0;
    endcase
  endfunction

  // A random coordinate in [-span, span], returned as a 32-bit int.
  function automatic int rand_crd(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Random pairs. A fifth of them are raw noise on every field, so that every
  // bit toggles; the rest are geometry at three scales, with radii on the order
  // of the distances so that hits and misses both come up often.
  function automatic shape_pair_t random_pair();
    shape_pair_t p;
    int mode;
    int span;
    mode = $urandom_range(9);
    p.kind = spit_pkg::kind_t'($urandom_range(3));
    p.typed = 1'b0;
    p.typed_hit = 1'b0;
    if (mode < 2) begin
      p.pos_a    = $urandom;
      p.pos_b    = $urandom;
      p.radius_a = spit_pkg::rad_t'($urandom);
      p.radius_b = spit_pkg::rad_t'($urandom);
      p.offset_a = $urandom;
      p.offset_b = $urandom;
      p.seg_vec  = $urandom;
    end else begin
      span = (mode < 6) ? 1024 : (mode < 9) ? 8192 : 32767;
      p.pos_a    = pk(rand_crd(span), rand_crd(span));
      p.pos_b    = pk(rand_crd(span), rand_crd(span));
      p.offset_a = pk(rand_crd(span / 4), rand_crd(span / 4));
      p.offset_b = pk(rand_crd(span / 4), rand_crd(span / 4));
      p.seg_vec  = ($urandom_range(9) == 0) ? pk(0, 0) :
                   pk(rand_crd(2 * span < 32767 ? 2 * span : 32767),
                      rand_crd(2 * span < 32767 ? 2 * span : 32767));
      p.radius_a = spit_pkg::rad_t'($urandom_range(span));
      p.radius_b = spit_pkg::rad_t'($urandom_range(span));
    end
    return p;
  endfunction

  // Offers one pair on the input channel, after a random number of idle
  // cycles, and returns once the transfer has happened. Valid only drops when
  // an idle cycle follows, so each step sees at most one update of it.
  task automatic send_pair(shape_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    pair_on_port <= p;
    do @(posedge clk); while (in_stall);
  endtask

  // The receiver stalls at random at the rate that the current phase sets.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Scoreboard. Both channels are sampled at the clock edge, so the values
  // seen are the ones the block saw. Results are checked before the pair of
  // the same edge is queued, though no pair can come out in its own cycle.
  always @(posedge clk) begin
    bit want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (hits_due_q.size() == 0) begin
          $display("%0t: hit %b came out with no pair pending", $time, out_hit);
          fail_count++;
        end else begin
          want = hits_due_q.pop_front();
          if (out_hit !== want) begin
            $display("%0t: hit mismatch, expected %b, got %b", $time, want, out_hit);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        hits_due_q.push_back(pair_on_port.typed ? pair_on_port.typed_hit
                                                : shapes_touch(pair_on_port));
    end
  end

  // Watchdog: any transfer, or reset, restarts the count of quiet cycles.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    shape_pair_t directed_rows[$];
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    pair_on_port <= mk(spit_pkg::KIND_NONE, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);

    // Directed rows. Q8.8 throughout, so 256 is one unit. The last two fields
    // give the hand-worked answer where one is obvious.
    // Unsupported pairs miss whatever the fields hold.
    directed_rows.push_back(mk(spit_pkg::KIND_NONE, '1, '1, '1, '1, '1, '1, '1, 1, 0));
    directed_rows.push_back(mk(spit_pkg::KIND_NONE, pk(0, 0), pk(0, 0), 256, 256,
                               '0, '0, pk(256, 0), 1, 0));
    // Circle-circle: coincident zero circles, exact touch, just apart.
    directed_rows.push_back(mk(spit_pkg::KIND_CC, '0, '0, '0, '0, '0, '0, '0, 1, 1));
    directed_rows.push_back(mk(spit_pkg::KIND_CC, pk(0, 0), pk(512, 0), 256, 256,
                               '0, '0, '0, 1, 1));
    directed_rows.push_back(mk(spit_pkg::KIND_CC, pk(0, 0), pk(513, 0), 256, 256,
                               '0, '0, '0, 1, 0));
    // Opposite corners of the coordinate range, with zero and with full radii.
    directed_rows.push_back(mk(spit_pkg::KIND_CC, pk(-32768, -32768), pk(32767, 32767),
                               0, 0, '0, '0, '0, 1, 0));
    directed_rows.push_back(mk(spit_pkg::KIND_CC, pk(-32768, -32768), pk(32767, 32767),
                               16'hFFFF, 16'hFFFF, '1, '1, '1, 1, 1));
    // Offsets would bring these circles together, but circle-circle ignores them.
    directed_rows.push_back(mk(spit_pkg::KIND_CC, pk(0, 0), pk(1000, 0), 100, 100,
                               pk(1000, 0), '0, '0, 1, 0));
    // Segment through the centre.
    directed_rows.push_back(mk(spit_pkg::KIND_CS, pk(0, 0), pk(-1024, 0), 256, 0,
                               '0, '0, pk(2048, 0), 1, 1));
    // Parallel segment farther than the radius from the centre.
    directed_rows.push_back(mk(spit_pkg::KIND_CS, pk(0, 0), pk(-1024, 512), 256, 0,
                               '0, '0, pk(2048, 0), 1, 0));
    // On the centre's line but wholly beyond the circle.
    directed_rows.push_back(mk(spit_pkg::KIND_CS, pk(0, 0), pk(512, 0), 256, 0,
                               '0, '0, pk(512, 0), 1, 0));
    // Endpoint strictly inside, centre projecting outside the segment.
    directed_rows.push_back(mk(spit_pkg::KIND_CS, pk(0, 0), pk(128, 0), 256, 0,
                               '0, '0, pk(512, 0), 1, 1));
    // Endpoint exactly on the rim does not count as inside.
    directed_rows.push_back(mk(spit_pkg::KIND_CS, pk(0, 0), pk(256, 0), 256, 0,
                               '0, '0, pk(512, 0), 1, 0));
    // Zero-length segment, inside and on the rim.
    directed_rows.push_back(mk(spit_pkg::KIND_CS, pk(0, 0), pk(100, 0), 256, 0,
                               '0, '0, '0, 1, 1));
    directed_rows.push_back(mk(spit_pkg::KIND_CS, pk(0, 0), pk(256, 0), 256, 0,
                               '0, '0, '0, 1, 0));
    // The segment side's radius is ignored even at its maximum.
    directed_rows.push_back(mk(spit_pkg::KIND_CS, pk(0, 0), pk(1024, 1024), 256, 16'hFFFF,
                               '0, '0, pk(256, 0), 1, 0));
    // Segment tangent to the circle: the line distance equals the radius.
    directed_rows.push_back(mk(spit_pkg::KIND_CS, pk(0, 0), pk(-1024, 256), 256, 0,
                               '0, '0, pk(2048, 0), 1, 1));
    // Centre projecting exactly onto the segment's start point.
    directed_rows.push_back(mk(spit_pkg::KIND_CS, pk(0, 0), pk(0, 128), 256, 0,
                               '0, '0, pk(512, 0), 1, 1));
    // Offsets move both shapes onto each other.
    directed_rows.push_back(mk(spit_pkg::KIND_CS, pk(4096, 0), pk(0, 4096), 256, 0,
                               pk(-4096, 0), pk(-1024, -4096), pk(2048, 0), 1, 1));
    // Segment A against circle B, with A's radius at its maximum and ignored.
    directed_rows.push_back(mk(spit_pkg::KIND_SC, pk(-1024, 0), pk(0, 0), 16'hFFFF, 256,
                               '0, '0, pk(2048, 0), 1, 1));
    directed_rows.push_back(mk(spit_pkg::KIND_SC, pk(-1024, 0), pk(0, 0), 0, 256,
                               '0, pk(0, 2048), pk(2048, 0), 1, 0));
    // Extremes of every field, and one ordinary pair, left to the predictor.
    directed_rows.push_back(mk(spit_pkg::KIND_CS, 32'h8000_8000, 32'h7FFF_7FFF,
                               16'hFFFF, 0, 32'h8000_8000, 32'h7FFF_7FFF,
                               32'h8000_8000, 0, 0));
    directed_rows.push_back(mk(spit_pkg::KIND_SC, 32'h7FFF_7FFF, 32'h8000_8000,
                               0, 16'hFFFF, 32'h7FFF_7FFF, 32'h8000_8000,
                               32'h7FFF_7FFF, 0, 0));
    directed_rows.push_back(mk(spit_pkg::KIND_SC, pk(-300, -300), pk(100, 50), 0, 200,
                               pk(20, -10), pk(-5, 5), pk(600, 700), 0, 0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Three idling phases: a slow receiver, then a slow sender, then neither.
    // The directed rows go first, in the slow receiver phase.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 7;  recv_idle_pct = 62; end
        1: begin send_idle_pct = 62; recv_idle_pct = 7;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (phase == 0)
        foreach (directed_rows[i]) send_pair(directed_rows[i]);
      repeat (PAIRS_A_PHASE) send_pair(random_pair());
    end
    in_valid <= 1'b0;

    // Wait for every due result, then a few more cycles so that a spurious
    // extra result would still be caught. The watchdog bounds both waits.
    while (hits_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
